### hw/rtl/ptct_pkg.sv
// Package with constants, types and the arctangent table of the point transform unit.
package ptct_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int NUM_ROT       = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

   localparam int LOW_BITS = FRAC_BITS + 3;
   localparam int HI_BITS  = 32 - LOW_BITS;
   localparam int U_OFF    = 45 * ((2 ** (HI_BITS - 1) + 44) / 45);
   localparam int U_ADD    = U_OFF - 2 ** (HI_BITS - 1);
   localparam int U_BITS   = HI_BITS + 1;
   localparam int RCP_SH   = U_BITS + 6;
   localparam int RCP      = (2 ** RCP_SH + 44) / 45;
   localparam int RCP_BITS = RCP_SH - 4;
   localparam int PRD_BITS = U_BITS + RCP_BITS;

   localparam int AW        = 34;
   localparam int ANG_SHIFT = 24 - FRAC_BITS;
   localparam logic signed [AW-1:0] FULL    = AW'(longint'(360) <<< FRAC_BITS);
   localparam logic signed [AW-1:0] HALF    = AW'(longint'(180) <<< FRAC_BITS);
   localparam logic signed [AW-1:0] QUARTER = AW'(longint'(90) <<< FRAC_BITS);

   localparam int TW = 32;
   localparam logic signed [TW-1:0] CORDIC_X0 = TW'(163008219);

   localparam int DW    = 34;
   localparam int PW    = DW + TW;
   localparam int SW    = PW + 1;
   localparam int DB    = 35;
   localparam int DEN_W = 24;

   localparam logic signed [31:0] OUT_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] OUT_MIN = 32'sh80000000;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ZERO = 2'd1;
   localparam logic [1:0] STATUS_OVF  = 2'd2;

   typedef struct packed {
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic signed [31:0]   pivot_x;
      logic signed [31:0]   pivot_y;
      logic signed [23:0]   scale_x;
      logic signed [23:0]   scale_y;
   } side_type;

   typedef struct packed {
      logic signed [31:0] pivot_x;
      logic signed [31:0] pivot_y;
      logic               qneg_x;
      logic               qneg_y;
      logic               rneg_x;
      logic               rneg_y;
      logic               zero_x;
      logic               zero_y;
   } fin_type;

   function automatic logic signed [AW-1:0] atan_q24(input logic [4:0] idx);
      logic signed [AW-1:0] v;
      unique case (idx)
         5'd0:  v = 34'sd754974720;
         5'd1:  v = 34'sd445687602;
         5'd2:  v = 34'sd235489088;
         5'd3:  v = 34'sd119537938;
         5'd4:  v = 34'sd60000934;
         5'd5:  v = 34'sd30029717;
         5'd6:  v = 34'sd15018523;
         5'd7:  v = 34'sd7509720;
         5'd8:  v = 34'sd3754917;
         5'd9:  v = 34'sd1877466;
         5'd10: v = 34'sd938734;
         5'd11: v = 34'sd469367;
         5'd12: v = 34'sd234684;
         5'd13: v = 34'sd117342;
         5'd14: v = 34'sd58671;
         5'd15: v = 34'sd29335;
         5'd16: v = 34'sd14668;
         5'd17: v = 34'sd7334;
         5'd18: v = 34'sd3667;
         5'd19: v = 34'sd1833;
         5'd20: v = 34'sd917;
         5'd21: v = 34'sd458;
         5'd22: v = 34'sd229;
         5'd23: v = 34'sd115;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### hw/rtl/parent_to_child_point_transform_unit.sv
// Top level of the parent-to-child point transform unit.
//
//   Channel  Ports               Direction  Content
//   req      req_valid/req_stall in         point, placement, scale, angle
//   rsp      rsp_valid/rsp_stall out        local point and status
//
// One word enters per cycle while the output is not stalled. The pipeline holds one register
// per CORDIC rotation and one per quotient bit of the divider.
// Reset clears the valid bits of every stage. When the output holds a word that is
// stalled, the whole pipeline holds and req_stall is raised.
module parent_to_child_point_transform_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_child_pos_x,
   input  logic signed [31:0] req_child_pos_y,
   input  logic signed [31:0] req_pivot_x,
   input  logic signed [31:0] req_pivot_y,
   input  logic signed [23:0] req_scale_x,
   input  logic signed [23:0] req_scale_y,
   input  logic signed [31:0] req_angle_deg,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_local_x,
   output logic signed [31:0] rsp_local_y,
   output logic [1:0]         rsp_status
);

   localparam int NR = ptct_pkg::NUM_ROT;
   localparam int DB = ptct_pkg::DB;
   localparam int AW = ptct_pkg::AW;
   localparam int TW = ptct_pkg::TW;
   localparam int DW = ptct_pkg::DW;
   localparam int PW = ptct_pkg::PW;
   localparam int SW = ptct_pkg::SW;
   localparam int UB = ptct_pkg::U_BITS;
   localparam int LB = ptct_pkg::LOW_BITS;
   localparam int EW = ptct_pkg::DEN_W;

   logic move;
   assign move      = !(rsp_valid && rsp_stall);
   assign req_stall = !move;

   // Stage A: split the angle and form the offsets.
   logic               va_ff;
   logic [UB-1:0]      ua_ff;
   logic [LB-1:0]      loa_ff;
   ptct_pkg::side_type sa_ff;
   logic [UB-1:0]      ua_in;
   ptct_pkg::side_type sa_in;

   always_comb begin
      ua_in = UB'({~req_angle_deg[31], req_angle_deg[30:LB]}) + UB'(ptct_pkg::U_ADD);
      sa_in.dx = DW'(req_point_x) - DW'(req_child_pos_x) - DW'(req_pivot_x);
      sa_in.dy = DW'(req_point_y) - DW'(req_child_pos_y) - DW'(req_pivot_y);
      sa_in.pivot_x = req_pivot_x;
      sa_in.pivot_y = req_pivot_y;
      sa_in.scale_x = req_scale_x;
      sa_in.scale_y = req_scale_y;
   end

   // Stage B: reciprocal product for the remainder by 45.
   logic                          vb_ff;
   logic [UB-1:0]                 ub_ff;
   logic [LB-1:0]                 lob_ff;
   logic [ptct_pkg::PRD_BITS-1:0] pb_ff;
   ptct_pkg::side_type            sb_ff;

   // Stage C: angle reduced into one turn.
   logic               vc_ff;
   logic signed [AW-1:0] ac_ff;
   ptct_pkg::side_type sc_ff;
   logic [UB-1:0]      qc;
   logic [UB-1:0]      rc;
   logic [UB-1:0]      rc2;
   logic signed [AW-1:0] ac_in;

   always_comb begin
      qc  = UB'(pb_ff >> ptct_pkg::RCP_SH);
      rc  = ub_ff - UB'(qc * UB'(45));
      rc2 = (rc >= UB'(45)) ? rc - UB'(45) : rc;
      ac_in = AW'({rc2[5:0], lob_ff});
   end

   // Stage D: fold into the right half plane.
   logic signed [AW-1:0] zd_in;
   logic                 fd_in;
   logic signed [AW-1:0] a1;
   logic signed [AW-1:0] a2;

   always_comb begin
      a1 = (ac_ff > ptct_pkg::HALF) ? ac_ff - ptct_pkg::FULL : ac_ff;
      fd_in = 1'b0;
      a2 = a1;
      priority if (a1 > ptct_pkg::QUARTER) begin
         a2 = a1 - ptct_pkg::HALF;
         fd_in = 1'b1;
      end else if (a1 < -ptct_pkg::QUARTER) begin
         a2 = a1 + ptct_pkg::HALF;
         fd_in = 1'b1;
      end
      zd_in = a2 <<< ptct_pkg::ANG_SHIFT;
   end

   logic                 cv_ff [NR+1];
   logic signed [TW-1:0] cx_ff [NR+1];
   logic signed [TW-1:0] cy_ff [NR+1];
   logic signed [AW-1:0] cz_ff [NR+1];
   logic                 cf_ff [NR+1];
   ptct_pkg::side_type   cs_ff [NR+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
         vc_ff    <= 1'b0;
         cv_ff[0] <= 1'b0;
      end else if (move) begin
         va_ff    <= req_valid;
         vb_ff    <= va_ff;
         vc_ff    <= vb_ff;
         cv_ff[0] <= vc_ff;
      end
      if (move) begin
         ua_ff    <= ua_in;
         loa_ff   <= req_angle_deg[LB-1:0];
         sa_ff    <= sa_in;
         ub_ff    <= ua_ff;
         lob_ff   <= loa_ff;
         pb_ff    <= ptct_pkg::PRD_BITS'(ua_ff) *
                     ptct_pkg::PRD_BITS'(ptct_pkg::RCP);
         sb_ff    <= sa_ff;
         ac_ff    <= ac_in;
         sc_ff    <= sb_ff;
         cx_ff[0] <= ptct_pkg::CORDIC_X0;
         cy_ff[0] <= '0;
         cz_ff[0] <= zd_in;
         cf_ff[0] <= fd_in;
         cs_ff[0] <= sc_ff;
      end
   end

   for (genvar i = 0; i < NR; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (move) begin
            cv_ff[i+1] <= cv_ff[i];
         end
         if (move) begin
            if (!cz_ff[i][AW-1]) begin
               cx_ff[i+1] <= cx_ff[i] - (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] + (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] - ptct_pkg::atan_q24(5'(i));
            end else begin
               cx_ff[i+1] <= cx_ff[i] + (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] - (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] + ptct_pkg::atan_q24(5'(i));
            end
            cf_ff[i+1] <= cf_ff[i];
            cs_ff[i+1] <= cs_ff[i];
         end
      end
   end

   // Products, sums and magnitudes.
   logic                 vm_ff;
   logic signed [PW-1:0] xc_ff;
   logic signed [PW-1:0] ys_ff;
   logic signed [PW-1:0] yc_ff;
   logic signed [PW-1:0] xs_ff;
   ptct_pkg::side_type   sm_ff;
   logic signed [TW-1:0] cosv;
   logic signed [TW-1:0] sinv;

   assign cosv = cf_ff[NR] ? -cx_ff[NR] : cx_ff[NR];
   assign sinv = cf_ff[NR] ? -cy_ff[NR] : cy_ff[NR];

   logic                 vs_ff;
   logic signed [SW-1:0] rx_ff;
   logic signed [SW-1:0] ry_ff;
   ptct_pkg::side_type   ss_ff;

   logic                 dv_ff [DB+1];
   logic [DB-1:0]        nx_ff [DB+1];
   logic [DB-1:0]        ny_ff [DB+1];
   logic [EW-1:0]        rx_rem_ff [DB+1];
   logic [EW-1:0]        ry_rem_ff [DB+1];
   logic [EW-1:0]        ex_ff [DB+1];
   logic [EW-1:0]        ey_ff [DB+1];
   ptct_pkg::fin_type    df_ff [DB+1];

   logic [SW-1:0]        absx;
   logic [SW-1:0]        absy;
   ptct_pkg::fin_type    f_in;

   always_comb begin
      absx = rx_ff[SW-1] ? SW'(-rx_ff) : SW'(rx_ff);
      absy = ry_ff[SW-1] ? SW'(-ry_ff) : SW'(ry_ff);
      f_in.pivot_x = ss_ff.pivot_x;
      f_in.pivot_y = ss_ff.pivot_y;
      f_in.qneg_x  = rx_ff[SW-1] ^ ss_ff.scale_x[23];
      f_in.qneg_y  = ry_ff[SW-1] ^ ss_ff.scale_y[23];
      f_in.rneg_x  = rx_ff[SW-1];
      f_in.rneg_y  = ry_ff[SW-1];
      f_in.zero_x  = (ss_ff.scale_x == '0);
      f_in.zero_y  = (ss_ff.scale_y == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff    <= 1'b0;
         vs_ff    <= 1'b0;
         dv_ff[0] <= 1'b0;
      end else if (move) begin
         vm_ff    <= cv_ff[NR];
         vs_ff    <= vm_ff;
         dv_ff[0] <= vs_ff;
      end
      if (move) begin
         xc_ff <= PW'(cs_ff[NR].dx) * PW'(cosv);
         ys_ff <= PW'(cs_ff[NR].dy) * PW'(sinv);
         yc_ff <= PW'(cs_ff[NR].dy) * PW'(cosv);
         xs_ff <= PW'(cs_ff[NR].dx) * PW'(sinv);
         sm_ff <= cs_ff[NR];
         rx_ff <= SW'(xc_ff) + SW'(ys_ff);
         ry_ff <= SW'(yc_ff) - SW'(xs_ff);
         ss_ff <= sm_ff;
         nx_ff[0]     <= absx[DB+27:28];
         ny_ff[0]     <= absy[DB+27:28];
         rx_rem_ff[0] <= '0;
         ry_rem_ff[0] <= '0;
         ex_ff[0]     <= ss_ff.scale_x[23] ? EW'(-ss_ff.scale_x) : EW'(ss_ff.scale_x);
         ey_ff[0]     <= ss_ff.scale_y[23] ? EW'(-ss_ff.scale_y) : EW'(ss_ff.scale_y);
         df_ff[0] <= f_in;
      end
   end

   for (genvar k = 0; k < DB; k++) begin : g_div
      logic [EW-1:0] shx;
      logic [EW-1:0] shy;
      logic          gex;
      logic          gey;

      always_comb begin
         shx = {rx_rem_ff[k][EW-2:0], nx_ff[k][DB-1]};
         shy = {ry_rem_ff[k][EW-2:0], ny_ff[k][DB-1]};
         gex = (shx >= ex_ff[k]);
         gey = (shy >= ey_ff[k]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (move) begin
            dv_ff[k+1] <= dv_ff[k];
         end
         if (move) begin
            rx_rem_ff[k+1] <= gex ? shx - ex_ff[k] : shx;
            ry_rem_ff[k+1] <= gey ? shy - ey_ff[k] : shy;
            nx_ff[k+1]     <= {nx_ff[k][DB-2:0], gex};
            ny_ff[k+1]     <= {ny_ff[k][DB-2:0], gey};
            ex_ff[k+1]     <= ex_ff[k];
            ey_ff[k+1]     <= ey_ff[k];
            df_ff[k+1]     <= df_ff[k];
         end
      end
   end

   // Sign, pivot and saturation.
   logic                 vq_ff;
   logic signed [DB+1:0] lx_ff;
   logic signed [DB+1:0] ly_ff;
   ptct_pkg::fin_type    fq_ff;
   logic signed [DB:0]   qx;
   logic signed [DB:0]   qy;

   assign qx = df_ff[DB].qneg_x ? -$signed({1'b0, nx_ff[DB]}) : $signed({1'b0, nx_ff[DB]});
   assign qy = df_ff[DB].qneg_y ? -$signed({1'b0, ny_ff[DB]}) : $signed({1'b0, ny_ff[DB]});

   logic                 rsp_valid_ff;
   logic signed [31:0]   rsp_local_x_ff;
   logic signed [31:0]   rsp_local_y_ff;
   logic [1:0]           rsp_status_ff;
   logic signed [31:0]   ox_in;
   logic signed [31:0]   oy_in;
   logic [1:0]           st_in;
   logic                 ovx;
   logic                 ovy;

   always_comb begin
      ovx = 1'b0;
      ovy = 1'b0;
      priority if (fq_ff.zero_x) begin
         ox_in = fq_ff.rneg_x ? ptct_pkg::OUT_MIN : ptct_pkg::OUT_MAX;
      end else if (lx_ff > (DB+2)'(ptct_pkg::OUT_MAX)) begin
         ox_in = ptct_pkg::OUT_MAX;
         ovx = 1'b1;
      end else if (lx_ff < (DB+2)'(ptct_pkg::OUT_MIN)) begin
         ox_in = ptct_pkg::OUT_MIN;
         ovx = 1'b1;
      end else begin
         ox_in = lx_ff[31:0];
      end
      priority if (fq_ff.zero_y) begin
         oy_in = fq_ff.rneg_y ? ptct_pkg::OUT_MIN : ptct_pkg::OUT_MAX;
      end else if (ly_ff > (DB+2)'(ptct_pkg::OUT_MAX)) begin
         oy_in = ptct_pkg::OUT_MAX;
         ovy = 1'b1;
      end else if (ly_ff < (DB+2)'(ptct_pkg::OUT_MIN)) begin
         oy_in = ptct_pkg::OUT_MIN;
         ovy = 1'b1;
      end else begin
         oy_in = ly_ff[31:0];
      end
      priority if (fq_ff.zero_x || fq_ff.zero_y) begin
         st_in = ptct_pkg::STATUS_ZERO;
      end else if (ovx || ovy) begin
         st_in = ptct_pkg::STATUS_OVF;
      end else begin
         st_in = ptct_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vq_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         vq_ff        <= dv_ff[DB];
         rsp_valid_ff <= vq_ff;
      end
      if (move) begin
         lx_ff          <= (DB+2)'(qx) + (DB+2)'(df_ff[DB].pivot_x);
         ly_ff          <= (DB+2)'(qy) + (DB+2)'(df_ff[DB].pivot_y);
         fq_ff          <= df_ff[DB];
         rsp_local_x_ff <= ox_in;
         rsp_local_y_ff <= oy_in;
         rsp_status_ff  <= st_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_local_x = rsp_local_x_ff;
   assign rsp_local_y = rsp_local_y_ff;
   assign rsp_status  = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_zero_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ptct_pkg::STATUS_ZERO |->
         rsp_local_x == ptct_pkg::OUT_MAX || rsp_local_x == ptct_pkg::OUT_MIN ||
         rsp_local_y == ptct_pkg::OUT_MAX || rsp_local_y == ptct_pkg::OUT_MIN)
      else $error("zero scale status without a saturated axis");
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ptct_pkg::STATUS_OVF |->
         rsp_local_x == ptct_pkg::OUT_MAX || rsp_local_x == ptct_pkg::OUT_MIN ||
         rsp_local_y == ptct_pkg::OUT_MAX || rsp_local_y == ptct_pkg::OUT_MIN)
      else $error("overflow status without a saturated axis");
   a_hold_div: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(dv_ff[DB]) && $stable(vq_ff) && $stable(cv_ff[NR]))
      else $error("pipeline valid bits moved during a stall");
`endif

endmodule

### bench/tb_parent_to_child_point_transform_unit.sv
// Self-checking testbench of the parent-to-child point transform unit.
`timescale 1ns / 1ps

module tb_parent_to_child_point_transform_unit;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_WORDS   = 1750;
   localparam int DIRECTED_WORDS = 20;

   typedef struct {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [23:0] sx;
      logic signed [23:0] sy;
      logic signed [31:0] ang;
   } placement_word_type;

   typedef struct {
      logic signed [31:0] lx;
      logic signed [31:0] ly;
      logic [1:0]         status;
   } local_point_type;

   typedef struct {
      placement_word_type word;
      bit                 typed;
      local_point_type    result;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic signed [31:0] req_child_pos_x = '0;
   logic signed [31:0] req_child_pos_y = '0;
   logic signed [31:0] req_pivot_x = '0;
   logic signed [31:0] req_pivot_y = '0;
   logic signed [23:0] req_scale_x = '0;
   logic signed [23:0] req_scale_y = '0;
   logic signed [31:0] req_angle_deg = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_local_x;
   logic signed [31:0] rsp_local_y;
   logic [1:0]         rsp_status;

   local_point_type   expected_points[$];
   directed_row_type  directed_rows[DIRECTED_WORDS];
   int                mismatch_count = 0;
   int                idle_cycles = 0;
   bit                stimulus_done = 1'b0;
   int                rsp_wait = 0;
   bit                rsp_armed = 1'b0;

   always #5 clock = ~clock;

   parent_to_child_point_transform_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_child_pos_x(req_child_pos_x), .req_child_pos_y(req_child_pos_y),
      .req_pivot_x(req_pivot_x), .req_pivot_y(req_pivot_y),
      .req_scale_x(req_scale_x), .req_scale_y(req_scale_y),
      .req_angle_deg(req_angle_deg),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_local_x(rsp_local_x), .rsp_local_y(rsp_local_y), .rsp_status(rsp_status)
   );

   function automatic longint floor_shr(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-v - 1) >>> s) - 1;
   endfunction

   function automatic longint rotation_angle_step(int i);
      unique case (i)
         0: return 754974720;   1: return 445687602;   2: return 235489088;
         3: return 119537938;   4: return 60000934;    5: return 30029717;
         6: return 15018523;    7: return 7509720;     8: return 3754917;
         9: return 1877466;     10: return 938734;     11: return 469367;
         12: return 234684;     13: return 117342;     14: return 58671;
         15: return 29335;      16: return 14668;      17: return 7334;
         18: return 3667;       19: return 1833;       20: return 917;
         21: return 458;        22: return 229;        23: return 115;
         default: return 0;
      endcase
   endfunction

   // The quotient is truncated toward zero; the divisor includes the trig scale.
   function automatic longint place_axis(longint r, longint scale, longint pivot,
                                         inout bit zero, inout bit ovf);
      longint q;
      longint den;
      if (scale == 0) begin
         zero = 1'b1;
         return (r < 0) ? -64'sd2147483648 : 64'sd2147483647;
      end
      den = scale <<< 28;
      q = r / den + pivot;
      if (q > 64'sd2147483647) begin
         ovf = 1'b1;
         return 64'sd2147483647;
      end
      if (q < -64'sd2147483648) begin
         ovf = 1'b1;
         return -64'sd2147483648;
      end
      return q;
   endfunction

   function automatic local_point_type to_child_frame(placement_word_type w);
      longint full_turn;
      longint a;
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      longint dx;
      longint dy;
      longint rx;
      longint ry;
      bit     flip;
      bit     zero;
      bit     ovf;
      local_point_type res;
      full_turn = longint'(360) <<< ptct_pkg::FRAC_BITS;
      flip = 1'b0;
      zero = 1'b0;
      ovf = 1'b0;
      a = longint'(w.ang) % full_turn;
      if (a < 0) a += full_turn;
      if (a > (full_turn / 2)) a -= full_turn;
      if (a > (longint'(90) <<< ptct_pkg::FRAC_BITS)) begin
         a -= longint'(180) <<< ptct_pkg::FRAC_BITS;
         flip = 1'b1;
      end else if (a < -(longint'(90) <<< ptct_pkg::FRAC_BITS)) begin
         a += longint'(180) <<< ptct_pkg::FRAC_BITS;
         flip = 1'b1;
      end
      z = a <<< (24 - ptct_pkg::FRAC_BITS);
      x = 163008219;
      y = 0;
      for (int i = 0; i < ptct_pkg::CORDIC_STAGES && i < 24; i++) begin
         xs = floor_shr(x, i);
         ys = floor_shr(y, i);
         if (z >= 0) begin
            x -= ys;
            y += xs;
            z -= rotation_angle_step(i);
         end else begin
            x += ys;
            y -= xs;
            z += rotation_angle_step(i);
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      dx = longint'(w.px) - longint'(w.cx) - longint'(w.ox);
      dy = longint'(w.py) - longint'(w.cy) - longint'(w.oy);
      rx = dx * x + dy * y;
      ry = dy * x - dx * y;
      res.lx = 32'(place_axis(rx, longint'(w.sx), longint'(w.ox), zero, ovf));
      res.ly = 32'(place_axis(ry, longint'(w.sy), longint'(w.oy), zero, ovf));
      res.status = zero ? ptct_pkg::STATUS_ZERO
                        : (ovf ? ptct_pkg::STATUS_OVF : ptct_pkg::STATUS_OK);
      return res;
   endfunction

   function automatic placement_word_type make_word(int px, int py, int cx, int cy, int ox,
                                                    int oy, int sx, int sy, int ang);
      placement_word_type w;
      w.px = px; w.py = py; w.cx = cx; w.cy = cy; w.ox = ox; w.oy = oy;
      w.sx = 24'(sx); w.sy = 24'(sy); w.ang = ang;
      return w;
   endfunction

   function automatic logic [31:0] random_value32();
      unique case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
         2: return 32'($signed($urandom_range(0, 2000)) - 1000);
         3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      endcase
   endfunction

   function automatic logic [23:0] random_scale();
      unique case ($urandom_range(0, 7))
         0: return 24'd0;
         1: return 24'($urandom());
         2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         3: return 24'($signed($urandom_range(0, 64)) - 32);
         default: return 24'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      endcase
   endfunction

   function automatic placement_word_type random_word();
      placement_word_type w;
      w.px = random_value32(); w.py = random_value32();
      w.cx = random_value32(); w.cy = random_value32();
      w.ox = random_value32(); w.oy = random_value32();
      w.sx = ($urandom_range(0, 19) == 0) ? 24'd0 : random_scale();
      w.sy = random_scale();
      w.ang = random_value32();
      return w;
   endfunction

   task automatic send_word(placement_word_type w);
      int gap;
      gap = $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_point_x = w.px; req_point_y = w.py;
      req_child_pos_x = w.cx; req_child_pos_y = w.cy;
      req_pivot_x = w.ox; req_pivot_y = w.oy;
      req_scale_x = w.sx; req_scale_y = w.sy;
      req_angle_deg = w.ang;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   initial begin
      placement_word_type w;
      local_point_type    predicted;
      // After reset, identity, rotations, folds, zero scales, extremes and overflow.
      directed_rows[0] = '{make_word(0, 0, 0, 0, 0, 0, 65536, 65536, 0), 1'b0, '{0, 0, 0}};
      directed_rows[1] = '{make_word(65536, 131072, 0, 0, 0, 0, 65536, 65536, 0),
                           1'b0, '{0, 0, 0}};
      directed_rows[2] = '{make_word(65536, 0, 0, 0, 0, 0, 65536, 65536, 90 << 16),
                           1'b0, '{0, 0, 0}};
      directed_rows[3] = '{make_word(65536, 0, 0, 0, 0, 0, 65536, 65536, 180 << 16),
                           1'b0, '{0, 0, 0}};
      directed_rows[4] = '{make_word(65536, 0, 0, 0, 0, 0, 65536, 65536, 270 << 16),
                           1'b0, '{0, 0, 0}};
      directed_rows[5] = '{make_word(65536, 0, 0, 0, 0, 0, 65536, 65536, -(90 << 16)),
                           1'b0, '{0, 0, 0}};
      directed_rows[6] = '{make_word(65536, 0, 0, 0, 0, 0, 65536, 65536, 720 << 16),
                           1'b0, '{0, 0, 0}};
      directed_rows[7] = '{make_word(1, 1, 0, 0, 0, 0, 0, 0, 0),
                           1'b1, '{32'h7FFFFFFF, 32'h7FFFFFFF, ptct_pkg::STATUS_ZERO}};
      directed_rows[8] = '{make_word(-65536, -65536, 0, 0, 0, 0, 0, 0, 0),
                           1'b1, '{32'h80000000, 32'h80000000, ptct_pkg::STATUS_ZERO}};
      directed_rows[9] = '{make_word(0, 0, 0, 0, 0, 0, 0, 65536, 0),
                           1'b1, '{32'h7FFFFFFF, 0, ptct_pkg::STATUS_ZERO}};
      directed_rows[10] = '{make_word(32'h7FFFFFFF, 0, 32'h80000000, 0, 0, 0, 1, 65536, 0),
                            1'b0, '{0, 0, 0}};
      directed_rows[11] = '{make_word(32'h80000000, 0, 32'h7FFFFFFF, 0, 0, 0, 1, 65536, 0),
                            1'b0, '{0, 0, 0}};
      directed_rows[12] = '{make_word(65536, 65536, 0, 0, 0, 0, 1, 1, 0),
                            1'b0, '{0, 0, 0}};
      directed_rows[13] = '{make_word(32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0, 1, 0, 0),
                            1'b0, '{0, 0, 0}};
      directed_rows[14] = '{make_word(3 << 16, 5 << 16, 1 << 16, 1 << 16, 2 << 16, -(2 << 16),
                                      2 << 16, -(1 << 16), 45 << 16), 1'b0, '{0, 0, 0}};
      directed_rows[15] = '{make_word(65536, 65536, 0, 0, 32'h7FFFFFFF, 32'h80000000,
                                      24'h7FFFFF, 24'h800000, 32'h7FFFFFFF), 1'b0, '{0, 0, 0}};
      directed_rows[16] = '{make_word(-1, -1, -1, -1, -1, -1, -1, -1, 32'h80000000),
                            1'b0, '{0, 0, 0}};
      directed_rows[17] = '{make_word(10 << 16, 0, 0, 0, 0, 0, 65536, 65536, 135 << 16),
                            1'b0, '{0, 0, 0}};
      directed_rows[18] = '{make_word(10 << 16, 0, 0, 0, 0, 0, 65536, 65536, -(135 << 16)),
                            1'b0, '{0, 0, 0}};
      directed_rows[19] = '{make_word(0, 0, 0, 0, 0, 0, 65536, 65536, 32'h00000001),
                            1'b0, '{0, 0, 0}};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed_rows[i]) begin
         predicted = directed_rows[i].typed ? directed_rows[i].result
                                            : to_child_frame(directed_rows[i].word);
         expected_points = {expected_points, predicted};
         send_word(directed_rows[i].word);
      end
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         w = random_word();
         predicted = to_child_frame(w);
         expected_points = {expected_points, predicted};
         send_word(w);
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Each result word may be held back by rsp_stall for a random wait before it is taken.
   always @(negedge clock) begin
      if (reset) begin
         rsp_armed = 1'b0;
         rsp_wait = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_armed && !rsp_stall) begin
            rsp_armed = 1'b0;
         end
         if (rsp_valid && !rsp_armed) begin
            rsp_armed = 1'b1;
            rsp_wait = $urandom_range(0, 15);
         end
         if (rsp_armed && rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Unexpected result word: x=%0d y=%0d status=%0d",
                           rsp_local_x, rsp_local_y, rsp_status);
               end
            end else begin
               if (rsp_local_x !== expected_points[0].lx
                   || rsp_local_y !== expected_points[0].ly
                   || rsp_status !== expected_points[0].status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("Mismatch: exp x=%0d y=%0d st=%0d, got x=%0d y=%0d st=%0d",
                              expected_points[0].lx, expected_points[0].ly,
                              expected_points[0].status,
                              rsp_local_x, rsp_local_y, rsp_status);
                  end
               end
               void'(expected_points.pop_front());
            end
         end
      end
   end

   initial begin
      wait (stimulus_done && expected_points.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("Watchdog expired with %0d words outstanding.", expected_points.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
